// ----- rtl/core/wdu_pkg.sv -----
// shared item types, opcodes and state codes for the discriminator
package wdu_pkg;

	// width of the position fields of an input item
	localparam int POS_W = 6;

	// opcodes of an input item
	localparam logic [1:0] OP_MAP_WR   = 2'd0;
	localparam logic [1:0] OP_RET_WR   = 2'd1;
	localparam logic [1:0] OP_TRAIN    = 2'd2;
	localparam logic [1:0] OP_CLASSIFY = 2'd3;

	// retina_length after reset
	localparam logic [6:0] RETINA_LENGTH_RST = 7'd64;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [POS_W-1:0] position;
		logic [POS_W-1:0] mapped_position;
		logic             bit_value;
	} item_t;

	typedef struct packed {
		logic [3:0]  node_index;
		logic [15:0] count;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} seq_state_t;

	// one retina position issued into the address pipeline
	typedef struct packed {
		logic valid;
		logic in_range;
		logic bit_end;
		logic node_last;
		logic classify;
	} issue_ctl_t;

	// one finished node address headed for the counter bank
	typedef struct packed {
		logic valid;
		logic node_last;
		logic classify;
	} node_ctl_t;

endpackage

// ----- rtl/core/wdu_seq.sv -----
// sequencer: clearing pass, position issue and item control
module wdu_seq #(
	parameter int ADDRESS_BITS = 4,
	parameter int NODE_COUNT   = 16,
	parameter int LEN_W        = 7,
	parameter int P_W          = 6,
	parameter int B_W          = 2,
	parameter int K_W          = 4,
	parameter int CLR_AW       = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                start_classify,
	input  logic                adv,
	input  logic                pipe_busy,
	input  logic [LEN_W-1:0]    len,
	output logic                ready,
	output wdu_pkg::issue_ctl_t iss,
	output logic [P_W-1:0]      iss_p,
	output logic [B_W-1:0]      iss_b,
	output logic [K_W-1:0]      iss_k,
	output logic                clr_en,
	output logic [CLR_AW-1:0]   clr_addr
);
	import wdu_pkg::*;

	seq_state_t          state_q;
	seq_state_t          state_d;
	logic [P_W-1:0]      p_q;
	logic [B_W-1:0]      b_q;
	logic [K_W-1:0]      k_q;
	logic                cls_q;
	logic [CLR_AW-1:0]   clr_q;
	logic                bit_end;
	logic                node_last;
	logic                in_range;

	assign bit_end   = (b_q == B_W'(ADDRESS_BITS - 1));
	assign node_last = ((32'(p_q) + 32'd1) >= 32'(len));
	assign in_range  = (32'(p_q) < 32'(len));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			p_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			cls_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (start) begin
				p_q   <= '0;
				b_q   <= '0;
				k_q   <= '0;
				cls_q <= start_classify;
			end else if (state_q == ST_RUN && adv) begin
				p_q <= p_q + 1'b1;
				if (bit_end) begin
					b_q <= '0;
					k_q <= k_q + 1'b1;
				end else begin
					b_q <= b_q + 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ready   = 1'b0;
		clr_en  = 1'b0;
		iss     = '0;
		case (state_q)
			ST_CLEAR: begin
				clr_en = 1'b1;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				iss.valid     = 1'b1;
				iss.in_range  = in_range;
				iss.bit_end   = bit_end;
				iss.node_last = node_last;
				iss.classify  = cls_q;
				if (adv && bit_end && node_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign iss_p    = p_q;
	assign iss_b    = b_q;
	assign iss_k    = k_q;
	assign clr_addr = clr_q;

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pipe_busy)
		else $error("pipeline busy while idle");

	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> 32'(k_q) < NODE_COUNT)
		else $error("node index past last node");

	a_clear_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q != '1) |=>
		(state_q == ST_CLEAR && clr_q == $past(clr_q) + 1'b1))
		else $error("clearing pass skipped an entry");

	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == ST_RUN && p_q == '0 && b_q == '0 && k_q == '0))
		else $error("item did not start at position zero");

endmodule

// ----- rtl/core/wdu_addr_gen.sv -----
// node address pipeline: mapping read, retina read, address accumulate
module wdu_addr_gen #(
	parameter int MAX_RETINA   = 64,
	parameter int ADDRESS_BITS = 4,
	parameter int P_W          = 6,
	parameter int B_W          = 2,
	parameter int K_W          = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         map_we,
	input  logic                         ret_we,
	input  logic [wdu_pkg::POS_W-1:0]    wr_position,
	input  logic [wdu_pkg::POS_W-1:0]    wr_mapped,
	input  logic                         wr_bit,
	input  wdu_pkg::issue_ctl_t          iss,
	input  logic [P_W-1:0]               iss_p,
	input  logic [B_W-1:0]               iss_b,
	input  logic [K_W-1:0]               iss_k,
	output wdu_pkg::node_ctl_t           node,
	output logic [K_W-1:0]               node_k,
	output logic [ADDRESS_BITS-1:0]      node_addr,
	output logic                         busy
);
	import wdu_pkg::*;

	localparam int MAP_AW  = $clog2(MAX_RETINA);
	localparam int MAP_IN  = 2 ** POS_W;

	typedef logic [MAP_AW-1:0] mod_tab_t [MAP_IN];

	// mapped positions folded into the retina range, built at elaboration
	function automatic mod_tab_t build_mod_tab();
		mod_tab_t tab;
		for (int i = 0; i < MAP_IN; i++) begin
			tab[i] = MAP_AW'(i % MAX_RETINA);
		end
		return tab;
	endfunction

	localparam mod_tab_t MOD_TAB = build_mod_tab();

	logic [MAP_AW-1:0]       map_mem [MAX_RETINA];
	logic                    ret_mem [MAX_RETINA];
	logic [MAX_RETINA-1:0]   map_vld_q;

	logic                    wr_ok;
	logic [MAP_AW-1:0]       wr_idx;
	logic [MAP_AW-1:0]       rd_idx;
	logic [MAP_AW-1:0]       ret_idx;

	issue_ctl_t              ctl_s1;
	logic [P_W-1:0]          p_s1;
	logic [B_W-1:0]          b_s1;
	logic [K_W-1:0]          k_s1;
	logic [MAP_AW-1:0]       map_rd_s1;
	logic                    vld_s1;

	issue_ctl_t              ctl_s2;
	logic [B_W-1:0]          b_s2;
	logic [K_W-1:0]          k_s2;
	logic                    ret_s2;

	logic [ADDRESS_BITS-1:0] acc_q;
	logic [ADDRESS_BITS-1:0] acc_base;
	logic [ADDRESS_BITS-1:0] bit_mask;

	assign wr_ok  = (32'(wr_position) < MAX_RETINA);
	assign wr_idx = MAP_AW'(wr_position);
	assign rd_idx = MAP_AW'(iss_p);

	// mapping entries never written read as the identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
		end else if (map_we && wr_ok) begin
			map_vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we && wr_ok) begin
			map_mem[wr_idx] <= MOD_TAB[wr_mapped];
		end
		if (adv) begin
			map_rd_s1 <= map_mem[rd_idx];
			vld_s1    <= map_vld_q[rd_idx];
			p_s1      <= iss_p;
			b_s1      <= iss_b;
			k_s1      <= iss_k;
		end
	end

	assign ret_idx = vld_s1 ? map_rd_s1 : MAP_AW'(p_s1);

	always_ff @(posedge clk) begin
		if (ret_we && wr_ok) begin
			ret_mem[wr_idx] <= wr_bit;
		end
		if (adv) begin
			ret_s2 <= ret_mem[ret_idx];
			b_s2   <= b_s1;
			k_s2   <= k_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s1 <= iss;
			ctl_s2 <= ctl_s1;
		end
	end

	// lsb-first address build, positions past the length give zero
	assign acc_base  = (b_s2 == '0) ? '0 : acc_q;
	assign bit_mask  = ADDRESS_BITS'(1) << b_s2;
	assign node_addr = acc_base | ((ctl_s2.in_range && ret_s2) ? bit_mask : '0);

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid) begin
			acc_q <= node_addr;
		end
	end

	assign node.valid     = ctl_s2.valid & ctl_s2.bit_end;
	assign node.node_last = ctl_s2.node_last;
	assign node.classify  = ctl_s2.classify;
	assign node_k         = k_s2;
	assign busy           = ctl_s1.valid | ctl_s2.valid;

endmodule

// ----- rtl/core/wdu_cnt_bank.sv -----
// counter store with saturating read-modify-write and clearing port
module wdu_cnt_bank #(
	parameter int ADDRESS_BITS = 4,
	parameter int K_W          = 4,
	parameter int COUNT_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  wdu_pkg::node_ctl_t             node,
	input  logic [K_W-1:0]                 node_k,
	input  logic [ADDRESS_BITS-1:0]        node_addr,
	input  logic                           clr_en,
	input  logic [K_W+ADDRESS_BITS-1:0]    clr_addr,
	output wdu_pkg::node_ctl_t             res,
	output logic [K_W-1:0]                 res_k,
	output logic [COUNT_BITS-1:0]          res_count,
	output logic                           busy
);
	import wdu_pkg::*;

	localparam int CNT_AW    = K_W + ADDRESS_BITS;
	localparam int CNT_DEPTH = 2 ** CNT_AW;

	logic [COUNT_BITS-1:0] cnt_mem [CNT_DEPTH];

	node_ctl_t             ctl_s3;
	logic [CNT_AW-1:0]     a_s3;
	logic [COUNT_BITS-1:0] cnt_s3;
	logic [CNT_AW-1:0]     rd_addr;
	logic                  inc_we;

	assign rd_addr = {node_k, node_addr};
	assign inc_we  = adv && ctl_s3.valid && !ctl_s3.classify && (cnt_s3 != '1);

	always_ff @(posedge clk) begin
		if (clr_en) begin
			cnt_mem[clr_addr] <= '0;
		end else if (inc_we) begin
			cnt_mem[a_s3] <= cnt_s3 + 1'b1;
		end
		if (adv) begin
			cnt_s3 <= cnt_mem[rd_addr];
			a_s3   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= node;
		end
	end

	assign res       = ctl_s3;
	assign res_k     = a_s3[CNT_AW-1:ADDRESS_BITS];
	assign res_count = cnt_s3;
	assign busy      = ctl_s3.valid;

endmodule

// ----- rtl/core/wisard_discriminator_unit.sv -----
// top level of the weightless-network discriminator
//
// A write-mapping or write-retina-bit item is written into its store at the edge
// that takes it. A train or classify item walks the retina one position per cycle,
// held while a classify result waits in the full result register: the mapping
// table is read, then the retina bit it points to, and every ADDRESS_BITS positions
// one node address is done and its counter is read (and, for train, written back
// one higher, holding at the maximum). An item holds the input until its last
// position has left the pipeline. After reset the block runs a clearing pass over
// the 2^(K_W + ADDRESS_BITS) entries of the counter store (256 by default, with K_W
// the bits of the node index), one entry a cycle, and takes no item until it ends;
// configuration writes are taken only while the block is idle between items, at the
// same cycles as input items, and a write taken at the same edge as an item applies
// to that item. The result register lets the next item enter while the last classify
// result still waits.
module wisard_discriminator_unit #(
	parameter int MAX_RETINA   = 64,
	parameter int ADDRESS_BITS = 4,
	parameter int COUNT_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	// input items
	input  logic             item_valid,
	output logic             item_ready,
	input  wdu_pkg::item_t   item,
	// classify results
	output logic             result_valid,
	input  logic             result_ready,
	output wdu_pkg::result_t result,
	// retina_length register
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [6:0]       cfg_data
);
	import wdu_pkg::*;

	localparam int NODE_COUNT = (MAX_RETINA + ADDRESS_BITS - 1) / ADDRESS_BITS;
	localparam int LEN_W      = $clog2(MAX_RETINA + 1);
	localparam int P_W        = $clog2(NODE_COUNT * ADDRESS_BITS);
	localparam int B_W        = (ADDRESS_BITS > 1) ? $clog2(ADDRESS_BITS) : 1;
	localparam int K_W        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CLR_AW     = K_W + ADDRESS_BITS;

	logic [6:0]              retina_length_q;
	logic [LEN_W-1:0]        len_act;

	logic                    item_acc;
	logic                    map_we;
	logic                    ret_we;
	logic                    start;
	logic                    start_classify;
	logic                    adv;
	logic                    pipe_busy;
	logic                    ag_busy;
	logic                    bank_busy;

	issue_ctl_t              iss;
	logic [P_W-1:0]          iss_p;
	logic [B_W-1:0]          iss_b;
	logic [K_W-1:0]          iss_k;
	logic                    clr_en;
	logic [CLR_AW-1:0]       clr_addr;

	node_ctl_t               node;
	logic [K_W-1:0]          node_k;
	logic [ADDRESS_BITS-1:0] node_addr;

	node_ctl_t               res;
	logic [K_W-1:0]          res_k;
	logic [COUNT_BITS-1:0]   res_count;

	logic                    result_valid_q;
	result_t                 result_q;

	// config register, written only while no item is in flight
	assign cfg_ready = item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retina_length_q <= RETINA_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			retina_length_q <= cfg_data;
		end
	end

	// length in use: zero acts as one, too long clamps to the retina size
	always_comb begin
		if (retina_length_q == '0) begin
			len_act = LEN_W'(1);
		end else if (32'(retina_length_q) > MAX_RETINA) begin
			len_act = LEN_W'(MAX_RETINA);
		end else begin
			len_act = LEN_W'(retina_length_q);
		end
	end

	// item decode at the accepting edge
	assign item_acc       = item_valid & item_ready;
	assign map_we         = item_acc && (item.opcode == OP_MAP_WR);
	assign ret_we         = item_acc && (item.opcode == OP_RET_WR);
	assign start          = item_acc &&
		(item.opcode == OP_TRAIN || item.opcode == OP_CLASSIFY);
	assign start_classify = (item.opcode == OP_CLASSIFY);

	// the whole pipeline moves only when the result register can take a result
	assign adv       = !result_valid_q || result_ready;
	assign pipe_busy = ag_busy | bank_busy;

	wdu_seq #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.NODE_COUNT   (NODE_COUNT),
		.LEN_W        (LEN_W),
		.P_W          (P_W),
		.B_W          (B_W),
		.K_W          (K_W),
		.CLR_AW       (CLR_AW)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.start_classify (start_classify),
		.adv            (adv),
		.pipe_busy      (pipe_busy),
		.len            (len_act),
		.ready          (item_ready),
		.iss            (iss),
		.iss_p          (iss_p),
		.iss_b          (iss_b),
		.iss_k          (iss_k),
		.clr_en         (clr_en),
		.clr_addr       (clr_addr)
	);

	wdu_addr_gen #(
		.MAX_RETINA   (MAX_RETINA),
		.ADDRESS_BITS (ADDRESS_BITS),
		.P_W          (P_W),
		.B_W          (B_W),
		.K_W          (K_W)
	) u_addr_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.map_we      (map_we),
		.ret_we      (ret_we),
		.wr_position (item.position),
		.wr_mapped   (item.mapped_position),
		.wr_bit      (item.bit_value),
		.iss         (iss),
		.iss_p       (iss_p),
		.iss_b       (iss_b),
		.iss_k       (iss_k),
		.node        (node),
		.node_k      (node_k),
		.node_addr   (node_addr),
		.busy        (ag_busy)
	);

	wdu_cnt_bank #(
		.ADDRESS_BITS (ADDRESS_BITS),
		.K_W          (K_W),
		.COUNT_BITS   (COUNT_BITS)
	) u_cnt_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.node      (node),
		.node_k    (node_k),
		.node_addr (node_addr),
		.clr_en    (clr_en),
		.clr_addr  (clr_addr),
		.res       (res),
		.res_k     (res_k),
		.res_count (res_count),
		.busy      (bank_busy)
	);

	// result register, loaded with one node count per classify node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= res.valid & res.classify;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid && res.classify) begin
			result_q.node_index <= 4'(res_k);
			result_q.count      <= 16'(res_count);
			result_q.last       <= res.node_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
